// ----- hdl/crx_pkg.sv -----
// Shared types, constants and helper functions for the clique repair and expand block.
`timescale 1ns / 1ps
`default_nettype none

package crx_pkg;

  // Matrix geometry
  localparam int MAX_NODES = 64;
  localparam int ROW_W     = MAX_NODES;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int DEG_W     = 7;
  localparam int BEST_W    = DEG_W + 1;

  // Configuration register map
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;
  localparam int REG_NODE_COUNT = 0;
  localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(MAX_NODES);

  // Input actions
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_RUN  = 1'b1;

  typedef struct packed {
    logic             action;
    logic [5:0]       row_index;
    logic [63:0]      row_bits;
    logic [63:0]      vertex_mask;
    logic [5:0]       start_index;
  } crx_in_t;

  typedef struct packed {
    logic [63:0]      clique_mask;
    logic [6:0]       clique_size;
  } crx_out_t;

  // Row store access between sequencer and memory
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [ROW_W-1:0] wr_row;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
  } crx_mem_req_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [DEG_W-1:0] deg;
  } crx_mem_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CHECK,
    ST_EXPAND,
    ST_FINAL
  } crx_state_t;

  // Count set bits of one row
  function automatic logic [DEG_W-1:0] popcount(input logic [ROW_W-1:0] v);
    logic [DEG_W-1:0] c;
    c = '0;
    for (int i = 0; i < ROW_W; i++) begin
      c = c + DEG_W'(v[i]);
    end
    return c;
  endfunction

  // Ones in every bit position below n
  function automatic logic [ROW_W-1:0] low_mask(input logic [CNT_W-1:0] n);
    logic [ROW_W-1:0] m;
    for (int i = 0; i < ROW_W; i++) begin
      m[i] = (CNT_W'(i) < n);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/crx_store.sv -----
// Adjacency row memory with degree computed on write and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module crx_store
  import crx_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire crx_mem_req_t req,
  output crx_mem_rsp_t      rsp
);

  logic [ROW_W+DEG_W-1:0] mem [MAX_NODES];

  logic                   wr_pend_r;
  logic [IDX_W-1:0]       wr_idx_r;
  logic [ROW_W-1:0]       wr_row_r;
  logic [ROW_W+DEG_W-1:0] rd_word_r;

  // Register the write word so the degree is counted from the staged copy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pend_r <= 1'b0;
    end else begin
      wr_pend_r <= req.wr_en;
    end
    if (req.wr_en) begin
      wr_idx_r <= req.wr_idx;
      wr_row_r <= req.wr_row;
    end
  end

  // Write row and its degree, read one entry per cycle while rd_en is set
  always_ff @(posedge clk) begin
    if (wr_pend_r) begin
      mem[wr_idx_r] <= {popcount(wr_row_r), wr_row_r};
    end
    if (req.rd_en) begin
      rd_word_r <= mem[req.rd_idx];
    end
  end

  assign rsp.deg = rd_word_r[ROW_W+DEG_W-1:ROW_W];
  assign rsp.row = rd_word_r[ROW_W-1:0];

endmodule

`default_nettype wire

// ----- hdl/clique_repair_and_expand_top.sv -----
// Top level: load sequencer, repair/expand scan engine, output register and register port.
//
//   channel   | direction | handshake          | word
//   in_       | input     | in_valid/in_stall  | crx_in_t: load row or run on a vertex set
//   out_      | output    | out_valid/out_stall| crx_out_t: clique mask and size
//   APB       | config    | psel/penable/pready| node_count at byte address 0
//
// A load word passes through ST_LOAD before the next word is taken. A run word scans the row
// memory once per pass, one row per cycle through its single read port: a check pass for each
// vertex dropped by repair and one more, then an expand pass from the start index and a final
// pass. Reset clears control only; rows are undefined until loaded. A finished result
// waits in the output register; the next word is taken meanwhile, and a run that finishes
// while the previous result is still stalled holds until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module clique_repair_and_expand_top
  import crx_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input words
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire crx_in_t           in_data,
  // result words
  output logic                   out_valid,
  input  wire logic              out_stall,
  output crx_out_t               out_data,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  crx_state_t       state_r, state_nxt;

  logic [CNT_W-1:0] node_count_r;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] addr_r, addr_nxt;
  logic [IDX_W-1:0] start_r, start_nxt;
  logic [ROW_W-1:0] set_r, set_nxt;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             fail_r, fail_nxt;
  logic [IDX_W-1:0] best_r, best_nxt;
  logic [BEST_W-1:0] best_deg_r, best_deg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_vld_r, out_vld_nxt;
  crx_out_t         out_word_r, out_word_nxt;

  crx_mem_req_t     mem_req;
  crx_mem_rsp_t     mem_rsp;

  logic             accept;
  logic             scan_st;
  logic             more;
  logic             issue;
  logic             pass_done;
  logic             out_busy;
  logic             cfg_wr;
  logic [CNT_W-1:0] n_use;
  logic [ROW_W-1:0] rd_bit;
  logic [ROW_W-1:0] others;
  logic             row_bad;
  logic             row_fits;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[APB_AW-1:2] == (APB_AW-2)'(REG_NODE_COUNT));
  assign prdata = {{(APB_DW-CNT_W){1'b0}}, node_count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
    end else if (cfg_wr) begin
      node_count_r <= pwdata[CNT_W-1:0];
    end
  end

  assign n_use = (node_count_r > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_r;

  // Scan bookkeeping
  assign accept    = in_valid && !in_stall;
  assign scan_st   = (state_r == ST_CHECK) || (state_r == ST_EXPAND) ||
                     (state_r == ST_FINAL);
  assign more      = (addr_r < n_r);
  assign pass_done = !more && !rd_vld_r;
  assign out_busy  = out_vld_r && out_stall;

  // Per-row tests on the returned word
  assign rd_bit   = ROW_W'(1) << rd_idx_r;
  assign others   = set_r & ~rd_bit;
  assign row_bad  = (set_r[rd_idx_r]) && ((mem_rsp.row & others) != others);
  assign row_fits = !set_r[rd_idx_r] && ((mem_rsp.row & set_r) == set_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_data.action == ACT_LOAD) ? ST_LOAD : ST_CHECK;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_IDLE;
      end
      ST_CHECK: begin
        if (pass_done && !fail_r) begin
          state_nxt = ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        if (pass_done) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (pass_done && !out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    in_stall = (state_r != ST_IDLE);
    issue    = scan_st && more;
  end

  // Memory requests
  always_comb begin
    mem_req.wr_en  = accept && (in_data.action == ACT_LOAD);
    mem_req.wr_idx = in_data.row_index;
    mem_req.wr_row = in_data.row_bits & low_mask(CNT_W'(MAX_NODES));
    mem_req.rd_en  = issue;
    mem_req.rd_idx = addr_r[IDX_W-1:0];
  end

  // Datapath
  always_comb begin
    n_nxt        = n_r;
    addr_nxt     = addr_r;
    start_nxt    = start_r;
    set_nxt      = set_r;
    fail_nxt     = fail_r;
    best_nxt     = best_r;
    best_deg_nxt = best_deg_r;
    cnt_nxt      = cnt_r;
    out_vld_nxt  = out_vld_r && out_stall;
    out_word_nxt = out_word_r;

    if (issue) begin
      addr_nxt = addr_r + CNT_W'(1);
    end

    case (state_r)
      ST_IDLE: begin
        // Take a run word: trim the set to the vertices in use
        if (accept && (in_data.action == ACT_RUN)) begin
          n_nxt        = n_use;
          set_nxt      = in_data.vertex_mask & low_mask(n_use);
          start_nxt    = in_data.start_index;
          addr_nxt     = '0;
          fail_nxt     = 1'b0;
          best_deg_nxt = '1;
        end
      end
      ST_CHECK: begin
        // Test clique and track least-degree chosen vertex
        if (rd_vld_r && set_r[rd_idx_r]) begin
          if (row_bad) begin
            fail_nxt = 1'b1;
          end
          if (BEST_W'(mem_rsp.deg) < best_deg_r) begin
            best_deg_nxt = BEST_W'(mem_rsp.deg);
            best_nxt     = rd_idx_r;
          end
        end
        if (pass_done) begin
          if (fail_r) begin
            // Drop the weakest vertex and test again
            set_nxt[best_r] = 1'b0;
            addr_nxt        = '0;
            fail_nxt        = 1'b0;
            best_deg_nxt    = '1;
          end else begin
            addr_nxt = CNT_W'(start_r);
          end
        end
      end
      ST_EXPAND: begin
        // Add each candidate from the start index upward that is adjacent to every chosen vertex
        if (rd_vld_r && row_fits) begin
          set_nxt[rd_idx_r] = 1'b1;
        end
        if (pass_done) begin
          addr_nxt = '0;
          fail_nxt = 1'b0;
          cnt_nxt  = '0;
        end
      end
      ST_FINAL: begin
        // Confirm clique and count members
        if (rd_vld_r && set_r[rd_idx_r]) begin
          cnt_nxt = cnt_r + CNT_W'(1);
          if (row_bad) begin
            fail_nxt = 1'b1;
          end
        end
        if (pass_done && !out_busy) begin
          out_vld_nxt              = 1'b1;
          out_word_nxt.clique_mask = set_r;
          out_word_nxt.clique_size = fail_r ? '0 : cnt_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      addr_r    <= '0;
      n_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_vld_r  <= issue;
      out_vld_r <= out_vld_nxt;
      addr_r    <= addr_nxt;
      n_r       <= n_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_idx_r   <= addr_r[IDX_W-1:0];
    start_r    <= start_nxt;
    set_r      <= set_nxt;
    fail_r     <= fail_nxt;
    best_r     <= best_nxt;
    best_deg_r <= best_deg_nxt;
    cnt_r      <= cnt_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_word_r;

  crx_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rsp   (mem_rsp)
  );

endmodule

`default_nettype wire

// ----- hdl/crx_check.sv -----
// Port-level checks on the clique repair and expand top level, bound to it.
`timescale 1ns / 1ps
`default_nettype none

module crx_check
  import crx_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire crx_out_t out_data
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // Size never exceeds the matrix
  a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.clique_size <= 7'(MAX_NODES))
    else $error("clique size out of range");

  // A nonzero size counts the mask
  a_size_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.clique_size != '0) |->
      ($countones(out_data.clique_mask) == int'(out_data.clique_size)))
    else $error("clique size disagrees with mask");

  // An accepted word blocks the next cycle
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("word taken while previous still in work");

endmodule

bind clique_repair_and_expand_top crx_check u_crx_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
